// File: hw/rtl/largest_gap_bisect_channel_picker_macros.svh
// Assertion macros for the channel picker checker.
`ifndef LARGEST_GAP_BISECT_CHANNEL_PICKER_MACROS_SVH
`define LARGEST_GAP_BISECT_CHANNEL_PICKER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LGBCP_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LGBCP_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, live through reset.
`define LGBCP_ASSERT_ALW(label, clk_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lgbcp_pkg.sv
package lgbcp_pkg;

  localparam int NUM_CHANNELS = 1024;
  localparam int CHAN_W       = 10;
  localparam int STEP_W       = 5;
  localparam int RND_W        = 9;
  localparam int CNT_W        = $clog2(CHAN_W);

  localparam logic KIND_SCHEDULE = 1'b0;
  localparam logic KIND_CLEAR    = 1'b1;

  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] range_low;
    logic [CHAN_W-1:0] range_high;
    logic              direction;
    logic [RND_W-1:0]  random_value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [CHAN_W-1:0] channel;
  } resp_t;

  function automatic logic [CHAN_W-1:0] sat_chan(input logic [CHAN_W-1:0] v);
    return (v > LAST_CHAN) ? LAST_CHAN : v;
  endfunction

endpackage

// File: hw/rtl/lgbcp_align.sv
// Rounds a channel down to a multiple of the step: bit-serial remainder, one bit a cycle.
module lgbcp_align (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [lgbcp_pkg::CHAN_W-1:0]      value,
  input  logic [lgbcp_pkg::STEP_W-1:0]      step,
  output logic                              done,
  output logic [lgbcp_pkg::CHAN_W-1:0]      result
);

  logic                             active;
  logic [lgbcp_pkg::CNT_W-1:0]      cnt;
  logic [lgbcp_pkg::CHAN_W-1:0]     val;
  logic [lgbcp_pkg::STEP_W-1:0]     dvs;
  logic [lgbcp_pkg::STEP_W-1:0]     rem;
  logic [lgbcp_pkg::STEP_W:0]       trial;

  assign trial  = {rem, val[cnt]};
  assign result = val - lgbcp_pkg::CHAN_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        val    <= value;
        dvs    <= (step == '0) ? lgbcp_pkg::STEP_W'(1) : step;
        rem    <= '0;
        cnt    <= lgbcp_pkg::CNT_W'(lgbcp_pkg::CHAN_W - 1);
      end else if (active) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= lgbcp_pkg::STEP_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[lgbcp_pkg::STEP_W-1:0];
        end
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/largest_gap_bisect_channel_picker.sv
// Picks a channel in the widest untried gap of a range (its middle, or a point offset by the
// random value when the gap is wider than four), rounded down to a multiple of align_step. A
// transaction is taken when start is high and busy low; each transaction gives exactly one
// result, shown for a single cycle with done high, and the receiver cannot stall it, so it
// must capture resp whenever done is seen. The tried bitmap lives in a memory read one bit a
// cycle, which sets the rate. A schedule transaction that picks a channel marks range_low and
// range_high as tried, scans the range, picks, aligns in ten remainder steps, writes the pick
// back as tried and shows the result; one whose widest gap is too narrow skips alignment and
// write-back; a range with low not below high also skips the scan. A clear transaction sweeps
// all 1024 entries. After reset the same clearing sweep runs with busy high and gives no
// result. align_step may be written only while busy is low and no result is pending.
module largest_gap_bisect_channel_picker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  lgbcp_pkg::req_t                req,
  output logic                           busy,
  output logic                           done,
  output lgbcp_pkg::resp_t               resp,
  input  logic                           cfg_we,
  input  logic [lgbcp_pkg::STEP_W-1:0]   cfg_wdata
);

  localparam int CW = lgbcp_pkg::CHAN_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CLR     = 3'd1;
  localparam logic [2:0] ST_MARK_LO = 3'd2;
  localparam logic [2:0] ST_MARK_HI = 3'd3;
  localparam logic [2:0] ST_SCAN    = 3'd4;
  localparam logic [2:0] ST_CALC    = 3'd5;
  localparam logic [2:0] ST_ALIGN   = 3'd6;
  localparam logic [2:0] ST_WRITE   = 3'd7;

  logic [2:0]                      state;
  logic [lgbcp_pkg::STEP_W-1:0]    align_step;

  logic                            tried_mem [lgbcp_pkg::NUM_CHANNELS];
  logic                            mem_we;
  logic [CW-1:0]                   mem_waddr;
  logic                            mem_wdata;
  logic                            rd_bit;

  logic [CW-1:0]                   lo;
  logic [CW-1:0]                   hi;
  logic                            dir;
  logic [lgbcp_pkg::RND_W-1:0]     rnd;
  logic                            clr_report;

  logic [CW-1:0]                   ptr;
  logic [CW-1:0]                   end_ch;
  logic                            iss_vld;
  logic                            chk_vld;
  logic [CW-1:0]                   chk_ptr;
  logic [CW-1:0]                   prev;
  logic [CW-1:0]                   best_p1;
  logic [CW-1:0]                   run_start;
  logic [CW-1:0]                   run_stop;
  logic [CW-1:0]                   aligned;

  logic                            is_tried;
  logic [CW-1:0]                   len_p1;
  logic [CW-1:0]                   best;
  logic [CW-2:0]                   half;
  logic [CW-3:0]                   quart;
  logic [CW-2:0]                   r_sat;
  logic [CW:0]                     far_sum;
  logic [CW:0]                     mid_sum;
  logic [CW-1:0]                   pick_calc;

  logic                            al_go;
  logic                            al_done;
  logic [CW-1:0]                   al_result;

  assign busy = (state != ST_IDLE);

  // scan datapath
  assign is_tried = rd_bit || (chk_ptr == end_ch);
  assign len_p1   = dir ? (prev - chk_ptr) : (chk_ptr - prev);

  // pick datapath
  assign best      = best_p1 - 1'b1;
  assign half      = best[CW-1:1];
  assign quart     = half[CW-2:1];
  assign r_sat     = (CW'(rnd) > CW'(half)) ? half : (CW-1)'(rnd);
  assign far_sum   = {1'b0, run_start} + (CW+1)'(r_sat) + (CW+1)'(quart);
  assign mid_sum   = {1'b0, run_start} + {1'b0, run_stop};
  assign pick_calc = (best > CW'(4))
                   ? ((far_sum > (CW+1)'(lgbcp_pkg::LAST_CHAN))
                      ? lgbcp_pkg::LAST_CHAN : far_sum[CW-1:0])
                   : mid_sum[CW:1];

  assign al_go = (state == ST_CALC) && (best_p1 > CW'(2));

  lgbcp_align u_align (
    .clk    (clk),
    .rst    (rst),
    .go     (al_go),
    .value  (pick_calc),
    .step   (align_step),
    .done   (al_done),
    .result (al_result)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = 1'b0;
    unique case (state)
      ST_CLR: begin
        mem_we = 1'b1;
      end
      ST_MARK_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = 1'b1;
      end
      ST_MARK_HI: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = 1'b1;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = aligned;
        mem_wdata = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tried_mem[mem_waddr] <= mem_wdata;
    end
    rd_bit <= tried_mem[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      align_step <= lgbcp_pkg::STEP_W'(1);
    end else if (cfg_we) begin
      align_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      ptr        <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      iss_vld    <= 1'b0;
      chk_vld    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            lo  <= lgbcp_pkg::sat_chan(req.range_low);
            hi  <= lgbcp_pkg::sat_chan(req.range_high);
            dir <= req.direction;
            rnd <= req.random_value;
            if (req.kind == lgbcp_pkg::KIND_CLEAR) begin
              state      <= ST_CLR;
              ptr        <= '0;
              clr_report <= 1'b1;
            end else begin
              state <= ST_MARK_LO;
            end
          end
        end
        ST_CLR: begin
          if (ptr == lgbcp_pkg::LAST_CHAN) begin
            state <= ST_IDLE;
            if (clr_report) begin
              done <= 1'b1;
              resp <= '0;
            end
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        ST_MARK_LO: begin
          state <= ST_MARK_HI;
        end
        ST_MARK_HI: begin
          best_p1 <= '0;
          prev    <= dir ? hi : lo;
          end_ch  <= dir ? lo : hi;
          ptr     <= dir ? (hi - 1'b1) : (lo + 1'b1);
          chk_vld <= 1'b0;
          if (lo < hi) begin
            iss_vld <= 1'b1;
            state   <= ST_SCAN;
          end else begin
            state <= ST_CALC;
          end
        end
        ST_SCAN: begin
          chk_vld <= iss_vld;
          chk_ptr <= ptr;
          if (iss_vld) begin
            if (ptr == end_ch) begin
              iss_vld <= 1'b0;
            end else begin
              ptr <= dir ? (ptr - 1'b1) : (ptr + 1'b1);
            end
          end
          if (chk_vld && is_tried) begin
            if (len_p1 > best_p1) begin
              best_p1   <= len_p1;
              run_start <= dir ? chk_ptr : prev;
              run_stop  <= dir ? prev : chk_ptr;
            end
            prev <= chk_ptr;
          end
          if (chk_vld && (chk_ptr == end_ch)) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (best_p1 > CW'(2)) begin
            state <= ST_ALIGN;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
            resp  <= '0;
          end
        end
        ST_ALIGN: begin
          if (al_done) begin
            aligned <= al_result;
            state   <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state        <= ST_IDLE;
          done         <= 1'b1;
          resp.found   <= 1'b1;
          resp.channel <= aligned;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/lgbcp_checker.sv
`include "largest_gap_bisect_channel_picker_macros.svh"

module lgbcp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input lgbcp_pkg::resp_t              resp
);

  logic accept;

  assign accept = start && !busy;

  `LGBCP_ASSERT_NXT(a_accept_busy, clk, rst, accept, busy, "transaction taken but not busy")
  `LGBCP_ASSERT_IMP(a_miss_zero, clk, rst, done && !resp.found, resp.channel == '0,
                    "not-found result with non-zero channel")
  `LGBCP_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result strobe longer than a cycle")
  `LGBCP_ASSERT_ALW(a_sweep_after_rst, clk, $past(rst) && !rst, busy && !done,
                    "clearing sweep not running after reset")

endmodule

bind largest_gap_bisect_channel_picker lgbcp_checker u_lgbcp_checker (.*);

// File: tb/sv/channel_pick_checker.sv
`timescale 1ns / 100ps

module channel_pick_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  lgbcp_pkg::req_t              req,
  input  logic                         busy,
  input  logic                         done,
  input  lgbcp_pkg::resp_t             resp,
  input  logic                         cfg_we,
  input  logic [lgbcp_pkg::STEP_W-1:0] cfg_wdata,
  output int                           fail_count,
  output int                           outstanding
);
  import lgbcp_pkg::*;

  bit   [NUM_CHANNELS-1:0] tried_chan;
  logic [STEP_W-1:0]       step_copy;
  resp_t                   pending_picks[$];
  int                      fails = 0;

  assign fail_count = fails;

  task automatic report_fail(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic predict_pick(input req_t r, output resp_t o);
    int lo;
    int hi;
    int best;
    int seg_lo;
    int seg_hi;
    int prev;
    int run;
    int half;
    int quart;
    int offs;
    int pick;
    int stride;
    o = '0;
    if (r.kind == KIND_CLEAR) begin
      tried_chan = '0;
    end else begin
      lo = (int'(r.range_low) >= NUM_CHANNELS) ? NUM_CHANNELS - 1 : int'(r.range_low);
      hi = (int'(r.range_high) >= NUM_CHANNELS) ? NUM_CHANNELS - 1 : int'(r.range_high);
      best = -1;
      seg_lo = 0;
      seg_hi = 0;
      tried_chan[lo] = 1'b1;
      tried_chan[hi] = 1'b1;
      if (r.direction == 1'b0) begin
        prev = lo;
        for (int j = lo + 1; j <= hi; j++) begin
          if (tried_chan[j]) begin
            run = j - prev - 1;
            if (run > best) begin
              best = run;
              seg_lo = prev;
              seg_hi = j;
            end
            prev = j;
          end
        end
      end else begin
        prev = hi;
        for (int j = hi - 1; j >= lo; j--) begin
          if (tried_chan[j]) begin
            run = prev - j - 1;
            if (run > best) begin
              best = run;
              seg_lo = j;
              seg_hi = prev;
            end
            prev = j;
          end
        end
      end
      if (best > 1) begin
        if (best > 4) begin
          half = best >> 1;
          quart = half >> 1;
          offs = (int'(r.random_value) > half) ? half : int'(r.random_value);
          pick = seg_lo + offs + quart;
        end else begin
          pick = (seg_lo + seg_hi) >> 1;
        end
        stride = (step_copy == '0) ? 1 : int'(step_copy);
        pick = pick - (pick % stride);
        if (pick >= NUM_CHANNELS) pick = NUM_CHANNELS - 1;
        tried_chan[pick] = 1'b1;
        o.found = 1'b1;
        o.channel = CHAN_W'(pick);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    resp_t want;
    resp_t next_pick;
    if (rst) begin
      tried_chan = '0;
      step_copy = STEP_W'(1);
      pending_picks.delete();
    end else begin
      if (done) begin
        if (pending_picks.size() == 0) begin
          report_fail($sformatf("mismatch: result found=%0b channel=%0d with nothing expected",
                                resp.found, resp.channel));
        end else begin
          want = pending_picks.pop_front();
          if (resp.found !== want.found)
            report_fail($sformatf("mismatch on found: got %0b, expected %0b",
                                  resp.found, want.found));
          if (resp.channel !== want.channel)
            report_fail($sformatf("mismatch on channel: got %0d, expected %0d",
                                  resp.channel, want.channel));
        end
      end
      if (cfg_we) step_copy = cfg_wdata;
      if (start && !busy) begin
        predict_pick(req, next_pick);
        pending_picks.push_back(next_pick);
      end
    end
    outstanding <= pending_picks.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lgbcp_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  req_t              req = '0;
  logic              cfg_we = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;
  logic              busy;
  logic              done;
  resp_t             resp;
  int                fail_count;
  int                outstanding;
  bit                quiet_phase = 1'b0;

  always #6 clk = ~clk;

  largest_gap_bisect_channel_picker i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .resp      (resp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  channel_pick_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req         (req),
    .busy        (busy),
    .done        (done),
    .resp        (resp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic req_t make_req(input logic kind, input int lo, input int hi,
                                    input int dir, input int rnd);
    req_t r;
    r.kind = kind;
    r.range_low = CHAN_W'(lo);
    r.range_high = CHAN_W'(hi);
    r.direction = 1'(dir);
    r.random_value = RND_W'(rnd);
    return r;
  endfunction

  function automatic int idle_cycles();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic int pick_offset();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 511);
  endfunction

  // start stays high across back-to-back transactions
  task automatic send(input req_t r);
    int gap;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_step(input int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= STEP_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_run(input int items);
    int sent;
    int width;
    int lo;
    int hi;
    int burst;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send(make_req(1'($urandom), $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        2: begin
          send(make_req(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        3: begin
          lo = $urandom_range(1, 1023);
          hi = $urandom_range(0, lo - 1);
          send(make_req(KIND_SCHEDULE, lo, hi, $urandom, pick_offset()));
          sent++;
        end
        default: begin
          width = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(2, 64);
          lo = $urandom_range(0, 1023 - width);
          hi = lo + width;
          burst = $urandom_range(3, 14);
          repeat (burst) begin
            send(make_req(KIND_SCHEDULE, lo, hi, $urandom, pick_offset()));
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int steps[7];
    steps = '{16, 0, 31, 3, 1, 7, 0};
    steps[6] = $urandom_range(2, 15);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    drain();

    send(make_req(KIND_CLEAR, 1023, 1023, 1, 511));
    send(make_req(KIND_SCHEDULE, 0, 1023, 0, 0));
    send(make_req(KIND_SCHEDULE, 0, 1023, 1, 511));
    send(make_req(KIND_SCHEDULE, 0, 1023, 0, 511));
    send(make_req(KIND_SCHEDULE, 5, 5, 0, 3));
    send(make_req(KIND_SCHEDULE, 10, 3, 1, 3));
    send(make_req(KIND_SCHEDULE, 1023, 1023, 1, 0));
    send(make_req(KIND_SCHEDULE, 0, 0, 0, 0));
    send(make_req(KIND_CLEAR, 0, 0, 0, 0));
    send(make_req(KIND_SCHEDULE, 100, 101, 0, 0));
    send(make_req(KIND_SCHEDULE, 100, 102, 0, 0));
    send(make_req(KIND_SCHEDULE, 200, 203, 0, 0));
    send(make_req(KIND_SCHEDULE, 210, 214, 1, 0));
    send(make_req(KIND_SCHEDULE, 220, 225, 0, 0));
    send(make_req(KIND_SCHEDULE, 230, 236, 0, 9));
    send(make_req(KIND_SCHEDULE, 240, 246, 1, 511));
    send(make_req(KIND_SCHEDULE, 300, 340, 0, 0));
    send(make_req(KIND_SCHEDULE, 300, 340, 1, 511));
    send(make_req(KIND_SCHEDULE, 300, 340, 0, 7));
    send(make_req(KIND_SCHEDULE, 300, 340, 1, 200));
    send(make_req(KIND_CLEAR, 0, 0, 0, 0));

    for (int p = 0; p < 7; p++) begin
      set_step(steps[p]);
      quiet_phase = (p == 2);
      if (p == 3) begin
        random_run(40);
        drain();
        random_run(40);
      end else begin
        random_run(80);
      end
    end
    quiet_phase = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
